@@ rtl/stable_priority_queue_core_assert.svh @@
// Assertion macros shared by the stable priority queue RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ rtl/spq_pkg.sv @@
// Package for the stable priority queue: word types, codes and the
// command and status structs between controller and datapath. No dependencies.
package spq_pkg;

	localparam int TAG_W  = 16;
	localparam int PRIO_W = 16;
	localparam int OCC_W  = 5;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		STAT_ENQUEUED  = 2'd0,
		STAT_DEQUEUED  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic                     op;
		logic [TAG_W-1:0]         item_tag;
		logic signed [PRIO_W-1:0] item_priority;
	} spq_req_t;

	typedef struct packed {
		status_t                  status;
		logic [TAG_W-1:0]         out_tag;
		logic signed [PRIO_W-1:0] out_priority;
		logic [OCC_W-1:0]         occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic    do_enq;
		logic    do_deq;
		logic    load_rsp;
		status_t status;
	} spq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} spq_flags_t;

endpackage

@@ rtl/stable_priority_queue_core.sv @@
// Stable priority queue: a result word is ready the cycle after its request is accepted.
// Throughput is one word per cycle while results are taken; the per-cell compare
// and shift of the sorted row does each enqueue or dequeue in its accepting cycle.
// Reset empties the queue and drops any held result; cell contents stay undefined.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module stable_priority_queue_core
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int TAG_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output spq_rsp_t rsp
);

	spq_cmd_t   cmd;
	spq_flags_t flags;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_op    (req.op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	spq_datapath #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_tag      (req.item_tag),
		.item_priority (req.item_priority),
		.flags         (flags),
		.rsp           (rsp)
	);

endmodule

@@ rtl/spq_ctrl.sv @@
// Controller of the stable priority queue: handshake state machine that
// decodes each accepted word into commands. Depends on spq_pkg.
module spq_ctrl
	import spq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic       req_op,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  spq_flags_t flags,
	output spq_cmd_t   cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   fire;

	// A held result that is taken this cycle frees the output register.
	assign req_ready = (state_q == ST_IDLE) || rsp_ready;
	assign fire      = req_valid && req_ready;
	assign rsp_valid = (state_q == ST_HOLD);

	always_comb begin
		cmd          = '0;
		cmd.load_rsp = fire;
		if (req_op == OP_ENQ) begin
			cmd.do_enq = fire && !flags.full;
			cmd.status = flags.full ? STAT_OVERFLOW : STAT_ENQUEUED;
		end else begin
			cmd.do_deq = fire && !flags.empty;
			cmd.status = flags.empty ? STAT_UNDERFLOW : STAT_DEQUEUED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fire) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (!fire && rsp_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/spq_datapath.sv @@
// Datapath of the stable priority queue: sorted row of cells with a
// comparator per cell, entry count and result register. Depends on spq_pkg.
`include "stable_priority_queue_core_assert.svh"

module spq_datapath
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int TAG_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_cmd_t                 cmd,
	input  logic [TAG_W-1:0]         item_tag,
	input  logic signed [PRIO_W-1:0] item_priority,
	output spq_flags_t               flags,
	output spq_rsp_t                 rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [TAG_BITS-1:0]       tag_q  [CAPACITY];
	logic signed [PRIO_W-1:0]  prio_q [CAPACITY];
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          cnt_nxt;
	logic [CAPACITY-1:0]       ge;
	logic [TAG_BITS+TAG_W-1:0] tag_in_ext;
	logic [TAG_BITS+TAG_W-1:0] tag_out_ext;
	logic [CNT_W+OCC_W-1:0]    occ_ext;
	logic [TAG_BITS-1:0]       new_tag;
	spq_rsp_t                  rsp_q;

	assign tag_in_ext  = {{TAG_BITS{1'b0}}, item_tag};
	assign new_tag     = tag_in_ext[TAG_BITS-1:0];
	assign tag_out_ext = {{TAG_W{1'b0}}, tag_q[0]};

	assign flags.full  = (cnt_q == CNT_W'(CAPACITY));
	assign flags.empty = (cnt_q == '0);

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.do_enq) cnt_nxt = cnt_q + 1'b1;
		if (cmd.do_deq) cnt_nxt = cnt_q - 1'b1;
	end
	assign occ_ext = {{OCC_W{1'b0}}, cnt_nxt};

	// The row stays sorted, so ge is a run of ones from the head: the new word
	// goes into the first cell that is not held with a priority at least its own.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ge[i] = (CNT_W'(i) < cnt_q) && (prio_q[i] >= item_priority);

		always_ff @(posedge clk) begin
			if (cmd.do_deq) begin
				if (i < CAPACITY - 1) begin
					tag_q[i]  <= tag_q[(i < CAPACITY - 1) ? i + 1 : i];
					prio_q[i] <= prio_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end else if (cmd.do_enq && !ge[i]) begin
				if (i == 0) begin
					tag_q[i]  <= new_tag;
					prio_q[i] <= item_priority;
				end else if (ge[(i > 0) ? i - 1 : 0]) begin
					tag_q[i]  <= new_tag;
					prio_q[i] <= item_priority;
				end else begin
					tag_q[i]  <= tag_q[(i > 0) ? i - 1 : 0];
					prio_q[i] <= prio_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q.status       <= cmd.status;
			rsp_q.out_tag      <= cmd.do_deq ? tag_out_ext[TAG_W-1:0] : '0;
			rsp_q.out_priority <= cmd.do_deq ? prio_q[0] : '0;
			rsp_q.occupancy    <= occ_ext[OCC_W-1:0];
		end
	end

	assign rsp = rsp_q;

	`SPQ_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(CAPACITY))
	`SPQ_ASSERT_NOW(a_head_sorted, clk, arst_n, cnt_q >= CNT_W'(2), prio_q[0] >= prio_q[1])
	`SPQ_ASSERT_NOW(a_one_op, clk, arst_n, 1'b1, !(cmd.do_enq && cmd.do_deq))
	`SPQ_ASSERT_NEXT(a_enq_count, clk, arst_n, cmd.do_enq, cnt_q == CNT_W'($past(cnt_q) + 1'b1))
	`SPQ_ASSERT_NEXT(a_deq_head, clk, arst_n, cmd.do_deq, rsp_q.out_priority == $past(prio_q[0]))

endmodule
